@@ rtl/lfu_pkg.sv @@
// Package for the LFU variable-block cache directory.
// Holds commands, controller states, command/status structs and defaults.
// No dependencies.
package lfu_pkg;

    localparam int unsigned DefSlots    = 16;
    localparam int unsigned AddrW       = 32;
    localparam int unsigned LenW        = 25;
    localparam int unsigned CountW      = 32;
    localparam int unsigned StampW      = 32;
    localparam int unsigned OffW        = 24;
    localparam int unsigned SlotOutW    = 4;
    localparam int unsigned RemW        = 5;
    localparam logic [LenW-1:0] DefCapacity = 25'd65536;

    typedef enum logic [2:0] {
        CMD_INSERT     = 3'd0,
        CMD_LOOKUP     = 3'd1,
        CMD_READ       = 3'd2,
        CMD_WRITE      = 3'd3,
        CMD_INVALIDATE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_PLACE,
        ST_DONE
    } state_t;

    // scan kinds run by the datapath
    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_LRU,
        SCAN_INVAL
    } scan_t;

    typedef struct packed {
        logic  load;       // capture input transaction
        logic  scan_start; // reset scan pointer and best
        logic  scan_step;  // examine one slot
        scan_t scan_kind;
        logic  evict;      // drop best slot
        logic  place;      // write new block
        logic  access;     // apply hit update
        logic  reject;     // mark rejected insert
        logic  out_load;   // move result to output register
    } dp_cmd_t;

    typedef struct packed {
        logic       scan_last;  // current slot is the last one
        logic       fits;       // len <= available and a slot is free
        logic       too_big;    // len > capacity
        logic       best_found; // scan found a slot
        logic [2:0] cmd;
    } dp_stat_t;

endpackage

@@ rtl/lfu_datapath.sv @@
// Datapath of the LFU cache directory: slot storage, one-slot-per-cycle scan unit,
// eviction, placement and output register. Uses lfu_pkg.
module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int unsigned SLOTS = DefSlots
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LenW-1:0]     cfg_data,
    input  logic [2:0]          in_cmd,
    input  logic [AddrW-1:0]    in_address,
    input  logic [LenW-1:0]     in_length,
    input  dp_cmd_t             dcmd,
    output dp_stat_t            dstat,
    output logic                hit,
    output logic [SlotOutW-1:0] slot,
    output logic [OffW-1:0]     offset,
    output logic                status,
    output logic [RemW-1:0]     removed_count,
    output logic [LenW-1:0]     free_bytes
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot storage
    logic [SLOTS-1:0]  valid_reg;
    logic [AddrW-1:0]  base_reg  [SLOTS];
    logic [LenW-1:0]   len_reg   [SLOTS];
    logic [CountW-1:0] use_reg   [SLOTS];
    logic [SLOTS-1:0]  dirty_reg;
    logic [StampW-1:0] stamp_reg [SLOTS];

    logic [StampW-1:0] next_stamp_reg;
    logic [LenW-1:0]   cap_reg;
    logic [LenW-1:0]   avail_reg;

    // captured transaction
    logic [2:0]        cmd_reg;
    logic [AddrW-1:0]  addr_reg;
    logic [LenW-1:0]   length_reg;

    // scan state
    logic [SW-1:0]     ptr_reg;
    logic              found_reg;
    logic [SW-1:0]     best_reg;
    logic [CountW-1:0] best_use_reg;
    logic [StampW-1:0] best_age_reg;
    logic [RemW-1:0]   rem_reg;
    logic              rej_reg;
    logic              hit_reg;
    logic [SW-1:0]     res_slot_reg;

    // current-slot compare logic
    logic [StampW-1:0] cur_age;
    logic [AddrW:0]    cur_end;
    logic [AddrW:0]    rng_end;
    logic              cur_holds;
    logic              cur_overlap;
    logic              cur_better_lru;
    logic              free_any;
    logic [SW-1:0]     free_idx;

    // result as seen by the output register (access lands in the same cycle)
    logic              hit_now;
    logic [SW-1:0]     slot_now;

    assign cur_age  = next_stamp_reg - stamp_reg[ptr_reg];
    assign cur_end  = {1'b0, base_reg[ptr_reg]} + {{(AddrW+1-LenW){1'b0}}, len_reg[ptr_reg]};
    assign rng_end  = {1'b0, addr_reg} + {{(AddrW+1-LenW){1'b0}}, length_reg};
    assign cur_holds = valid_reg[ptr_reg] && (addr_reg >= base_reg[ptr_reg])
                       && ({1'b0, addr_reg} < cur_end);
    assign cur_overlap = valid_reg[ptr_reg] && (length_reg != '0)
                         && (len_reg[ptr_reg] != '0)
                         && ({1'b0, base_reg[ptr_reg]} < rng_end)
                         && ({1'b0, addr_reg} < cur_end);
    assign cur_better_lru = !found_reg || (use_reg[ptr_reg] < best_use_reg)
                            || ((use_reg[ptr_reg] == best_use_reg) && (cur_age > best_age_reg));

    assign hit_now  = hit_reg || dcmd.access;
    assign slot_now = dcmd.access ? best_reg : res_slot_reg;

    // lowest free slot (priority encode over valid bits)
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign dstat.scan_last  = (ptr_reg == SW'(SLOTS - 1));
    assign dstat.fits       = free_any && (length_reg <= avail_reg);
    assign dstat.too_big    = (length_reg > cap_reg);
    assign dstat.best_found = found_reg;
    assign dstat.cmd        = cmd_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            next_stamp_reg <= '0;
            cap_reg        <= DefCapacity;
            avail_reg      <= DefCapacity;
            ptr_reg        <= '0;
            found_reg      <= 1'b0;
            rem_reg        <= '0;
            rej_reg        <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            valid_reg      <= '0;
            next_stamp_reg <= '0;
            cap_reg        <= cfg_data;
            avail_reg      <= cfg_data;
        end
        else
        begin
            if (dcmd.load)
            begin
                rem_reg <= '0;
                rej_reg <= 1'b0;
                hit_reg <= 1'b0;
            end
            if (dcmd.scan_start)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (dcmd.scan_step)
            begin
                ptr_reg <= ptr_reg + SW'(1);
                case (dcmd.scan_kind)
                    SCAN_FIND:
                    begin
                        if (cur_holds && (!found_reg || cur_age > best_age_reg))
                            found_reg <= 1'b1;
                    end
                    SCAN_LRU:
                    begin
                        if (valid_reg[ptr_reg] && cur_better_lru)
                            found_reg <= 1'b1;
                    end
                    SCAN_INVAL:
                    begin
                        if (cur_overlap)
                        begin
                            valid_reg[ptr_reg] <= 1'b0;
                            avail_reg <= avail_reg + len_reg[ptr_reg];
                            rem_reg   <= rem_reg + RemW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (dcmd.evict)
            begin
                valid_reg[best_reg] <= 1'b0;
                avail_reg <= avail_reg + len_reg[best_reg];
                rem_reg   <= rem_reg + RemW'(1);
            end
            if (dcmd.place)
            begin
                valid_reg[free_idx] <= 1'b1;
                next_stamp_reg <= next_stamp_reg + StampW'(1);
                avail_reg <= avail_reg - length_reg;
            end
            if (dcmd.access)
                hit_reg <= 1'b1;
            if (dcmd.reject)
                rej_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            cmd_reg      <= in_cmd;
            addr_reg     <= in_address;
            length_reg   <= in_length;
            res_slot_reg <= '0;
        end
        if (dcmd.scan_step)
        begin
            if (((dcmd.scan_kind == SCAN_FIND) && cur_holds
                 && (!found_reg || cur_age > best_age_reg))
                || ((dcmd.scan_kind == SCAN_LRU) && valid_reg[ptr_reg] && cur_better_lru))
            begin
                best_reg     <= ptr_reg;
                best_use_reg <= use_reg[ptr_reg];
                best_age_reg <= cur_age;
            end
        end
        if (dcmd.place)
        begin
            base_reg[free_idx]  <= addr_reg;
            len_reg[free_idx]   <= length_reg;
            use_reg[free_idx]   <= '0;
            dirty_reg[free_idx] <= 1'b0;
            stamp_reg[free_idx] <= next_stamp_reg;
            res_slot_reg        <= free_idx;
        end
        if (dcmd.access)
        begin
            res_slot_reg <= best_reg;
            if ((cmd_reg == CMD_READ || cmd_reg == CMD_WRITE) && (use_reg[best_reg] != '1))
                use_reg[best_reg] <= use_reg[best_reg] + CountW'(1);
            if (cmd_reg == CMD_WRITE)
                dirty_reg[best_reg] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (dcmd.out_load)
        begin
            hit           <= hit_now;
            slot          <= SlotOutW'(slot_now);
            offset        <= hit_now ? OffW'(addr_reg - base_reg[slot_now]) : '0;
            status        <= rej_reg;
            removed_count <= rem_reg;
            free_bytes    <= avail_reg;
        end
    end

endmodule

@@ rtl/lfu_ctrl.sv @@
// Controller FSM of the LFU cache directory: sequences scans, evictions,
// placement and the output handshake. Uses lfu_pkg.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t dstat,
    output dp_cmd_t  dcmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register may be refilled when empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_SCAN;
            ST_SCAN:
            begin
                case (dstat.cmd)
                    CMD_INSERT:
                        if (dstat.too_big || dstat.fits) state_next = ST_DONE;
                        else if (dstat.scan_last) state_next = ST_EVICT;
                    CMD_LOOKUP, CMD_READ, CMD_WRITE, CMD_INVALIDATE:
                        if (dstat.scan_last) state_next = ST_DONE;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_EVICT:
                state_next = ST_SCAN;
            ST_DONE:
                if (out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        dcmd           = '0;
        dcmd.scan_kind = SCAN_FIND;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dcmd.load       = 1'b1;
                    dcmd.scan_start = 1'b1;
                end
            end
            ST_SCAN:
            begin
                case (dstat.cmd)
                    CMD_INSERT:
                    begin
                        dcmd.scan_kind = SCAN_LRU;
                        if (dstat.too_big)
                            dcmd.reject = 1'b1;
                        else if (dstat.fits)
                            dcmd.place = 1'b1;
                        else
                            dcmd.scan_step = 1'b1;
                    end
                    CMD_LOOKUP, CMD_READ, CMD_WRITE:
                    begin
                        dcmd.scan_kind = SCAN_FIND;
                        dcmd.scan_step = 1'b1;
                    end
                    CMD_INVALIDATE:
                    begin
                        dcmd.scan_kind = SCAN_INVAL;
                        dcmd.scan_step = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_EVICT:
            begin
                dcmd.scan_start = 1'b1;
                dcmd.evict      = dstat.best_found;
            end
            ST_DONE:
            begin
                if ((dstat.cmd == CMD_LOOKUP || dstat.cmd == CMD_READ
                     || dstat.cmd == CMD_WRITE) && dstat.best_found && out_free)
                    dcmd.access = 1'b1;
                if (out_free)
                begin
                    dcmd.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/lfu_variable_block_cache_directory.sv @@
// Top level of the LFU variable-block cache directory.
// Joins lfu_ctrl and lfu_datapath; uses lfu_pkg.
//
// channel  | handshake           | payload
// cfg      | cfg_we              | cfg_data
// in       | in_valid / in_stall | cmd, address, length
// out      | out_valid/out_stall | hit, slot, offset, status, removed_count, free_bytes
//
// Operation: the scan unit examines one slot a cycle. Lookup, read, write and
// invalidate scan every slot and move their result to the output register once
// it is free. An insert that fits is placed at once; otherwise a full scan picks
// the least-used block (oldest on a tie) for eviction before a new scan. One
// transaction is in work at a time; the output register lets the next one
// start while a result waits. Reset or a capacity write empties the directory at once.
module lfu_variable_block_cache_directory
    import lfu_pkg::*;
#(
    parameter int unsigned SLOTS = DefSlots
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LenW-1:0]     cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic [AddrW-1:0]    address,
    input  logic [LenW-1:0]     length,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [SlotOutW-1:0] slot,
    output logic [OffW-1:0]     offset,
    output logic                status,
    output logic [RemW-1:0]     removed_count,
    output logic [LenW-1:0]     free_bytes
);

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dstat     (dstat),
        .dcmd      (dcmd)
    );

    lfu_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_cmd        (cmd),
        .in_address    (address),
        .in_length     (length),
        .dcmd          (dcmd),
        .dstat         (dstat),
        .hit           (hit),
        .slot          (slot),
        .offset        (offset),
        .status        (status),
        .removed_count (removed_count),
        .free_bytes    (free_bytes)
    );

endmodule

@@ rtl/lfu_checker.sv @@
// Port checker for the LFU cache directory, bound to the top level.
// Uses lfu_pkg widths.
module lfu_checker
    import lfu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                hit,
    input logic [OffW-1:0]     offset,
    input logic                status,
    input logic [RemW-1:0]     removed_count,
    input logic [LenW-1:0]     free_bytes
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(free_bytes) && $stable(hit))
        else $error("stalled result changed");

    // a miss reports no offset
    a_miss_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> offset == '0)
        else $error("offset on miss");

    // a rejected insert removes nothing and hits nothing
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !hit && removed_count == '0)
        else $error("rejected insert with side effects");

    // an accepted transaction stalls the input on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled while busy");

endmodule

bind lfu_variable_block_cache_directory lfu_checker u_lfu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .offset        (offset),
    .status        (status),
    .removed_count (removed_count),
    .free_bytes    (free_bytes)
);
